[rtl/box_blur_3x3_rgb_macros.svh]
// assertion helpers shared by the blur rtl
`ifndef BOX_BLUR_3X3_RGB_MACROS_SVH
`define BOX_BLUR_3X3_RGB_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define BBR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define BBR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BBR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define BBR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

[rtl/bbr_pkg.sv]
package bbr_pkg;

    localparam int CH_W        = 8;
    localparam int PIX_W       = 3 * CH_W;
    localparam int SUM_W       = 12;
    localparam int RECIP_W     = 17;
    localparam int RECIP_SHIFT = 16;
    localparam int PROD_W      = SUM_W + RECIP_W;
    localparam int WIDTH_REG_W  = 12;
    localparam int HEIGHT_REG_W = 16;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 1;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'd1;

    localparam logic [WIDTH_REG_W-1:0]  RESET_WIDTH  = 12'd640;
    localparam logic [HEIGHT_REG_W-1:0] RESET_HEIGHT = 16'd480;

    typedef logic [PIX_W-1:0] t_pix;

    // per-item control handed from the counters to the window stage
    typedef struct packed {
        logic emit;
        logic use_top;
        logic use_bot;
        logic use_left;
        logic use_right;
        logic row_end;
        logic frame_end;
    } t_s1_ctl;

    // 2^16 / count, rounded up; exact floor for sums up to 9 * 255
    function automatic logic [RECIP_W-1:0] bbr_recip(input logic [1:0] rows,
                                                     input logic [1:0] cols);
        logic [RECIP_W-1:0] r;
        case ({rows, cols})
            4'b0101: r = 17'd65536;
            4'b0110: r = 17'd32768;
            4'b1001: r = 17'd32768;
            4'b0111: r = 17'd21846;
            4'b1101: r = 17'd21846;
            4'b1010: r = 17'd16384;
            4'b1011: r = 17'd10923;
            4'b1110: r = 17'd10923;
            4'b1111: r = 17'd7282;
            default: r = 17'd65536;
        endcase
        return r;
    endfunction

endpackage

[rtl/bbr_pix_if.sv]
interface bbr_pix_if;
    import bbr_pkg::*;

    logic            valid;
    logic            ready;
    logic [CH_W-1:0] blue_in;
    logic [CH_W-1:0] green_in;
    logic [CH_W-1:0] red_in;
    logic            drain;

    modport source(output valid, output blue_in, output green_in, output red_in,
                   output drain, input ready);
    modport sink(input valid, input blue_in, input green_in, input red_in,
                 input drain, output ready);
endinterface

[rtl/bbr_res_if.sv]
interface bbr_res_if;
    import bbr_pkg::*;

    logic            valid;
    logic            ready;
    logic [CH_W-1:0] blue_out;
    logic [CH_W-1:0] green_out;
    logic [CH_W-1:0] red_out;
    logic            row_end;
    logic            frame_end;

    modport source(output valid, output blue_out, output green_out, output red_out,
                   output row_end, output frame_end, input ready);
    modport sink(input valid, input blue_out, input green_out, input red_out,
                 input row_end, input frame_end, output ready);
endinterface

[rtl/bbr_line_store.sv]
module bbr_line_store #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_rd_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_rd_addr,
    input  logic                         i_wr_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_wr_addr,
    input  bbr_pkg::t_pix                i_wr_pix,
    output bbr_pkg::t_pix                o_up,
    output bbr_pkg::t_pix                o_mid
);
    import bbr_pkg::*;

    t_pix r_upper  [0:MAX_WIDTH-1];
    t_pix r_middle [0:MAX_WIDTH-1];
    t_pix r_up_q;
    t_pix r_mid_q;
    logic r_fwd;
    t_pix r_fwd_up;
    t_pix r_fwd_mid;

    // the row above moves up one line as the new pixel lands in the middle line
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_upper[i_wr_addr] <= o_mid;
        end
        if (i_rd_en) begin
            r_up_q <= r_upper[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_middle[i_wr_addr] <= i_wr_pix;
        end
        if (i_rd_en) begin
            r_mid_q <= r_middle[i_rd_addr];
        end
    end

    // bypass when the read hits the column being written in the same cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else if (i_rd_en) begin
            r_fwd <= i_wr_en && (i_wr_addr == i_rd_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_fwd_up  <= o_mid;
            r_fwd_mid <= i_wr_pix;
        end
    end

    assign o_up  = r_fwd ? r_fwd_up  : r_up_q;
    assign o_mid = r_fwd ? r_fwd_mid : r_mid_q;

endmodule

[rtl/bbr_ctrl.sv]
`include "box_blur_3x3_rgb_macros.svh"

module bbr_ctrl #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_accept,
    input  logic                            i_cfg_we,
    input  logic [bbr_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [bbr_pkg::CFG_W-1:0]       i_cfg_data,
    output logic [$clog2(MAX_WIDTH)-1:0]    o_addr,
    output bbr_pkg::t_s1_ctl                o_ctl
);
    import bbr_pkg::*;

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int EW   = $clog2(MAX_WIDTH + 2);
    localparam int CMPW = (EW > WIDTH_REG_W) ? EW : WIDTH_REG_W;
    localparam int RW   = HEIGHT_REG_W + 1;

    logic [WIDTH_REG_W-1:0]  r_width;
    logic [HEIGHT_REG_W-1:0] r_height;
    logic [CW-1:0]           r_in_col;
    logic [CW-1:0]           r_out_col;
    logic [HEIGHT_REG_W-1:0] r_out_row;
    logic [EW-1:0]           r_acc;

    logic [CW-1:0]           n_in_col;
    logic [CW-1:0]           n_out_col;
    logic [HEIGHT_REG_W-1:0] n_out_row;
    logic [EW-1:0]           n_acc;

    logic [CMPW-1:0]         width_ext;
    logic [EW-1:0]           eff_w;
    logic [HEIGHT_REG_W-1:0] eff_h;
    logic [RW-1:0]           out_row_inc;
    t_s1_ctl                 ctl;

    always_comb begin
        width_ext = CMPW'(r_width);
        if (width_ext == '0) begin
            eff_w = EW'(1);
        end else if (width_ext > CMPW'(MAX_WIDTH)) begin
            eff_w = EW'(MAX_WIDTH);
        end else begin
            eff_w = EW'(width_ext);
        end
        eff_h = (r_height == '0) ? HEIGHT_REG_W'(1) : r_height;
        out_row_inc = RW'(r_out_row) + RW'(1);

        ctl.emit      = !(r_acc < (eff_w + EW'(1)));
        ctl.use_top   = (r_out_row != '0);
        ctl.use_bot   = out_row_inc < RW'(eff_h);
        ctl.use_left  = (r_out_col != '0);
        ctl.use_right = (EW'(r_out_col) + EW'(1)) < eff_w;
        ctl.row_end   = !ctl.use_right;
        ctl.frame_end = ctl.row_end && !ctl.use_bot;

        n_in_col = ((EW'(r_in_col) + EW'(1)) >= eff_w) ? '0 : r_in_col + CW'(1);
        n_acc     = r_acc;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        if (!ctl.emit) begin
            n_acc = r_acc + EW'(1);
        end else if (ctl.frame_end) begin
            n_acc     = '0;
            n_in_col  = '0;
            n_out_col = '0;
            n_out_row = '0;
        end else if (ctl.row_end) begin
            n_out_col = '0;
            n_out_row = out_row_inc[HEIGHT_REG_W-1:0];
        end else begin
            n_out_col = r_out_col + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= RESET_WIDTH;
            r_height <= RESET_HEIGHT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_WIDTH:  r_width  <= i_cfg_data[WIDTH_REG_W-1:0];
                REG_HEIGHT: r_height <= i_cfg_data[HEIGHT_REG_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_acc     <= '0;
        end else if (i_accept) begin
            r_in_col  <= n_in_col;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
            r_acc     <= n_acc;
        end
    end

    assign o_addr = r_in_col;
    assign o_ctl  = ctl;

    `BBR_ASSERT_NEXT(a_frame_restart, i_clk, i_rst_n, i_accept && ctl.emit && ctl.frame_end, (r_acc == '0) && (r_in_col == '0) && (r_out_row == '0), "counters not cleared after frame end")

endmodule

[rtl/bbr_window.sv]
`include "box_blur_3x3_rgb_macros.svh"

module bbr_window #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  bbr_pkg::t_pix                i_pix,
    input  bbr_pkg::t_s1_ctl             i_ctl,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_addr,
    input  bbr_pkg::t_pix                i_up,
    input  bbr_pkg::t_pix                i_mid,
    input  logic                         i_out_ready,
    output logic                         o_in_ready,
    output logic                         o_wr_en,
    output logic [$clog2(MAX_WIDTH)-1:0] o_wr_addr,
    output bbr_pkg::t_pix                o_wr_pix,
    output logic                         o_out_valid,
    output bbr_pkg::t_pix                o_out_pix,
    output logic                         o_row_end,
    output logic                         o_frame_end
);
    import bbr_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);

    logic               r_s1_valid;
    t_pix               r_s1_pix;
    t_s1_ctl            r_s1_ctl;
    logic [CW-1:0]      r_s1_addr;
    logic [2:0][2:0][PIX_W-1:0] r_win;
    logic [2:0][2:0][PIX_W-1:0] n_win;

    logic               r_out_valid;
    t_pix               r_out_pix;
    logic               r_row_end;
    logic               r_frame_end;

    logic               s1_adv;
    logic [2:0]         row_use;
    logic [2:0]         col_use;
    logic [1:0]         rows;
    logic [1:0]         cols;
    logic [RECIP_W-1:0] recip;
    logic [2:0][SUM_W-1:0]  sum;
    logic [2:0][PROD_W-1:0] prod;
    t_pix               mean;

    assign s1_adv     = r_s1_valid && (!r_s1_ctl.emit || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_adv;

    // window after this item's shift, then masked sums and mean by reciprocal
    always_comb begin
        n_win[0]    = r_win[1];
        n_win[1]    = r_win[2];
        n_win[2][0] = i_up;
        n_win[2][1] = i_mid;
        n_win[2][2] = r_s1_pix;

        row_use = {r_s1_ctl.use_bot, 1'b1, r_s1_ctl.use_top};
        col_use = {r_s1_ctl.use_right, 1'b1, r_s1_ctl.use_left};
        rows    = 2'd1 + 2'(r_s1_ctl.use_top) + 2'(r_s1_ctl.use_bot);
        cols    = 2'd1 + 2'(r_s1_ctl.use_left) + 2'(r_s1_ctl.use_right);
        recip   = bbr_recip(rows, cols);

        sum = '0;
        for (int c = 0; c < 3; c++) begin
            for (int r = 0; r < 3; r++) begin
                for (int ch = 0; ch < 3; ch++) begin
                    if (col_use[c] && row_use[r]) begin
                        sum[ch] = sum[ch] + SUM_W'(n_win[c][r][ch*CH_W +: CH_W]);
                    end
                end
            end
        end
        for (int ch = 0; ch < 3; ch++) begin
            prod[ch] = PROD_W'(sum[ch]) * PROD_W'(recip);
            mean[ch*CH_W +: CH_W] = prod[ch][RECIP_SHIFT +: CH_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1_pix  <= i_pix;
            r_s1_ctl  <= i_ctl;
            r_s1_addr <= i_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (s1_adv) begin
            if (r_s1_ctl.emit && r_s1_ctl.frame_end) begin
                r_win <= '0;
            end else begin
                r_win <= n_win;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv && r_s1_ctl.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_ctl.emit) begin
            r_out_pix   <= mean;
            r_row_end   <= r_s1_ctl.row_end;
            r_frame_end <= r_s1_ctl.frame_end;
        end
    end

    assign o_wr_en     = s1_adv;
    assign o_wr_addr   = r_s1_addr;
    assign o_wr_pix    = r_s1_pix;
    assign o_out_valid = r_out_valid;
    assign o_out_pix   = r_out_pix;
    assign o_row_end   = r_row_end;
    assign o_frame_end = r_frame_end;

    `BBR_ASSERT_NOW(a_hold_on_stall, i_clk, i_rst_n, r_s1_valid && r_s1_ctl.emit && r_out_valid && !i_out_ready, !o_in_ready, "input taken while window stage is blocked")
    `BBR_ASSERT_NEXT(a_result_lands, i_clk, i_rst_n, s1_adv && r_s1_ctl.emit, r_out_valid, "emitted word did not reach the output register")

endmodule

[rtl/box_blur_3x3_rgb.sv]
// channel   dir   handshake      payload
// i_pix     in    valid/ready    blue_in, green_in, red_in, drain
// o_res     out   valid/ready    blue_out, green_out, red_out, row_end, frame_end
// cfg       in    i_cfg_we       i_cfg_idx (0 width, 1 height), i_cfg_data
//
// one word per cycle sustained unless o_res stalls; each word passes memory read, then mean
// latency in words: output k leaves with input word k+width+1, so a frame needs width+1 drains
// i_rst_n is synchronous; it clears counters, window and valids and reloads 640x480,
// the line stores stay as they are
// a stalled output word blocks the window stage once the word there has a result;
// warm-up words without a result keep flowing, then one more input word is taken
`include "box_blur_3x3_rgb_macros.svh"

module box_blur_3x3_rgb #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    bbr_pix_if.sink                       i_pix,
    bbr_res_if.source                     o_res,
    input  logic                          i_cfg_we,
    input  logic [bbr_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [bbr_pkg::CFG_W-1:0]     i_cfg_data
);
    import bbr_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);

    logic          accept;
    logic          in_ready;
    t_pix          pix_in;
    t_s1_ctl       ctl;
    logic [CW-1:0] rd_addr;
    logic          wr_en;
    logic [CW-1:0] wr_addr;
    t_pix          wr_pix;
    t_pix          up;
    t_pix          mid;
    logic          out_valid;
    t_pix          out_pix;
    logic          row_end;
    logic          frame_end;

    assign accept = i_pix.valid && in_ready;

    // a drain word flows through as a black pixel
    assign pix_in = i_pix.drain ? '0 : {i_pix.red_in, i_pix.green_in, i_pix.blue_in};

    // raster counters, edge masks and the delayed output position
    bbr_ctrl #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_addr     (rd_addr),
        .o_ctl      (ctl)
    );

    // two previous rows, read on accept, rotated when the word leaves the window stage
    bbr_line_store #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_addr (rd_addr),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_pix  (wr_pix),
        .o_up      (up),
        .o_mid     (mid)
    );

    // 3x3 window, masked sums and the registered result
    bbr_window #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_window (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_pix       (pix_in),
        .i_ctl       (ctl),
        .i_addr      (rd_addr),
        .i_up        (up),
        .i_mid       (mid),
        .i_out_ready (o_res.ready),
        .o_in_ready  (in_ready),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_pix    (wr_pix),
        .o_out_valid (out_valid),
        .o_out_pix   (out_pix),
        .o_row_end   (row_end),
        .o_frame_end (frame_end)
    );

    assign i_pix.ready     = in_ready;
    assign o_res.valid     = out_valid;
    assign o_res.blue_out  = out_pix[0*CH_W +: CH_W];
    assign o_res.green_out = out_pix[1*CH_W +: CH_W];
    assign o_res.red_out   = out_pix[2*CH_W +: CH_W];
    assign o_res.row_end   = row_end;
    assign o_res.frame_end = frame_end;

    `BBR_ASSERT_NOW(a_frame_on_row, i_clk, i_rst_n, out_valid && frame_end, row_end, "lone frame end")

endmodule

[tb/tb_box_blur_3x3_rgb.sv]
`timescale 1ns / 100ps

module tb_box_blur_3x3_rgb;
    import bbr_pkg::*;

    localparam int     MAXW          = 2048;
    localparam int     LONG_HOLD     = 300;        // receiver hold-off, in cycles
    localparam int     SETTLE_CYCLES = 8;          // pause before a register write
    localparam int     TAIL_CYCLES   = 20;         // quiet time after the last result
    localparam int     RANDOM_WORDS  = 280;        // random words per idling phase
    localparam longint CYCLE_LIMIT   = 1_000_000;

    // one blurred output word
    typedef struct packed {
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] red;
        logic            row_end;
        logic            frame_end;
    } t_mean;

    // predicts the blurred stream and checks the block against it
    class blur_scoreboard;
        logic [WIDTH_REG_W-1:0]  width_reg;
        logic [HEIGHT_REG_W-1:0] height_reg;
        t_pix        upper_row [MAXW];
        t_pix        middle_row[MAXW];
        t_pix        win[3][3];           // [left, centre, right][top, mid, bottom]
        int unsigned in_col, in_row, out_col, out_row, taken;
        t_mean       expected_means[$];
        int          errors;

        function new();
            width_reg  = RESET_WIDTH;
            height_reg = RESET_HEIGHT;
            errors     = 0;
            foreach (upper_row[i]) begin
                upper_row[i]  = '0;
                middle_row[i] = '0;
            end
            clear_frame();
        endfunction

        function void clear_frame();
            foreach (win[c, r]) win[c][r] = '0;
            in_col  = 0;
            in_row  = 0;
            out_col = 0;
            out_row = 0;
            taken   = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            if (idx == REG_WIDTH) width_reg = data[WIDTH_REG_W-1:0];
            else height_reg = data[HEIGHT_REG_W-1:0];
        endfunction

        function int pending();
            return expected_means.size();
        endfunction

        // note one accepted input word, queue the output it releases
        function void take_word(t_pix px_in, logic drain_in);
            int unsigned w, h, ic, cnt;
            int unsigned sum[3];
            t_pix        px, up, mid, p;
            logic        use_t, use_b, use_l, use_r;
            t_mean       m;
            w  = (width_reg == 0) ? 1 : ((width_reg > MAXW) ? MAXW : width_reg);
            h  = (height_reg == 0) ? 1 : height_reg;
            px = drain_in ? '0 : px_in;
            ic = (in_col >= MAXW) ? 0 : in_col;

            up  = upper_row[ic];
            mid = middle_row[ic];
            upper_row[ic]  = mid;
            middle_row[ic] = px;

            win[0] = win[1];
            win[1] = win[2];
            win[2][0] = up;
            win[2][1] = mid;
            win[2][2] = px;

            if (ic + 1 >= w) begin
                in_col = 0;
                in_row = (in_row + 1) & 16'hFFFF;
            end else begin
                in_col = ic + 1;
            end

            if (taken < w + 1) begin
                taken++;
                return;
            end

            use_t = out_row > 0;
            use_b = out_row + 1 < h;
            use_l = out_col > 0;
            use_r = out_col + 1 < w;
            sum = '{0, 0, 0};
            cnt = 0;
            for (int c = 0; c < 3; c++) begin
                if ((c == 0 && !use_l) || (c == 2 && !use_r)) continue;
                for (int r = 0; r < 3; r++) begin
                    if ((r == 0 && !use_t) || (r == 2 && !use_b)) continue;
                    p = win[c][r];
                    sum[0] += p[7:0];
                    sum[1] += p[15:8];
                    sum[2] += p[23:16];
                    cnt++;
                end
            end

            m.blue      = 8'(sum[0] / cnt);
            m.green     = 8'(sum[1] / cnt);
            m.red       = 8'(sum[2] / cnt);
            m.row_end   = out_col + 1 >= w;
            m.frame_end = m.row_end && (out_row + 1 >= h);
            expected_means.insert(expected_means.size(), m);

            if (m.frame_end) begin
                clear_frame();
            end else if (m.row_end) begin
                out_col = 0;
                out_row = (out_row + 1) & 16'hFFFF;
            end else begin
                out_col++;
            end
        endfunction

        function void note_error(string what, t_mean want, t_mean got);
            errors++;
            if (errors <= 10)
                $display("%0t %s: exp %0d %0d %0d %0b %0b got %0d %0d %0d %0b %0b",
                         $realtime, what, want.blue, want.green, want.red, want.row_end,
                         want.frame_end, got.blue, got.green, got.red, got.row_end,
                         got.frame_end);
        endfunction

        function void check_mean(t_mean got);
            t_mean want;
            if (expected_means.size() == 0) begin
                note_error("unexpected word", '0, got);
                return;
            end
            want = expected_means.pop_front();
            if (got.blue !== want.blue || got.green !== want.green || got.red !== want.red ||
                got.row_end !== want.row_end || got.frame_end !== want.frame_end)
                note_error("mismatch", want, got);
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    bbr_pix_if pix_if();
    bbr_res_if res_if();

    box_blur_3x3_rgb #(.MAX_WIDTH(MAXW)) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pix      (pix_if),
        .o_res      (res_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    blur_scoreboard sb;

    int     send_idle_pct = 0;   // chance per cycle that the sender holds back
    int     stall_pct     = 0;   // chance per cycle that the receiver stalls
    int     holds_asked   = 0;   // long hold-offs requested of the receiver
    int     words_sent    = 0;
    longint cycles        = 0;

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // both handshakes sampled in one process: input words are noted before
    // any output of the same edge is checked
    always @(posedge i_clk) begin
        if (i_rst_n && pix_if.valid && pix_if.ready)
            sb.take_word({pix_if.red_in, pix_if.green_in, pix_if.blue_in}, pix_if.drain);
        if (i_rst_n && res_if.valid && res_if.ready)
            sb.check_mean({res_if.blue_out, res_if.green_out, res_if.red_out,
                           res_if.row_end, res_if.frame_end});
    end

    // receiver: random stalls, plus a long hold-off whenever one is asked for
    initial begin
        int hold_left;
        int holds_done;
        hold_left  = 0;
        holds_done = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left == 0 && holds_done != holds_asked) begin
                holds_done++;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // offer one word, with random idle cycles first, and wait for its handshake;
    // valid is left high so back-to-back words need no extra assignment
    task automatic push_word(input t_pix px, input logic drain_in);
        while ($urandom_range(99) < send_idle_pct) begin
            pix_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix_if.valid    <= 1'b1;
        pix_if.blue_in  <= px[7:0];
        pix_if.green_in <= px[15:8];
        pix_if.red_in   <= px[23:16];
        pix_if.drain    <= drain_in;
        do @(posedge i_clk); while (!pix_if.ready);
        words_sent++;
    endtask

    // stop offering, wait until every expected word is out, then let the pipeline empty
    task automatic settle();
        pix_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // register writes, only with the block idle between frames
    task automatic set_frame_size(input logic [WIDTH_REG_W-1:0] w_field,
                                  input logic [HEIGHT_REG_W-1:0] h_field);
        logic [CFG_W-1:0] wdata;
        settle();
        // the bits above the width register are junk the block must drop
        wdata = {4'($urandom), w_field};
        pix_if.valid <= 1'b0;
        i_cfg_we     <= 1'b1;
        i_cfg_idx    <= REG_WIDTH;
        i_cfg_data   <= wdata;
        sb.write_reg(REG_WIDTH, wdata);
        @(posedge i_clk);
        i_cfg_idx  <= REG_HEIGHT;
        i_cfg_data <= h_field;
        sb.write_reg(REG_HEIGHT, h_field);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // whole frames back to back, each followed by width+1 drain words;
    // noise_pct of the pixels are drains inside the frame (black pixels)
    task automatic play_frames(input logic [WIDTH_REG_W-1:0] w_field,
                               input logic [HEIGHT_REG_W-1:0] h_field,
                               input int nframes, input int noise_pct);
        int unsigned w, h;
        w = (w_field == 0) ? 1 : ((w_field > MAXW) ? MAXW : w_field);
        h = (h_field == 0) ? 1 : h_field;
        repeat (nframes) begin
            for (int unsigned i = 0; i < w * h; i++)
                push_word(t_pix'($urandom), $urandom_range(99) < noise_pct);
            repeat (w + 1) push_word(t_pix'($urandom), 1'b1);
        end
    endtask

    // random small frames, a few wider ones
    task automatic random_frames(input int words);
        int unsigned w, h, target;
        target = words_sent + words;
        while (words_sent < target) begin
            w = ($urandom_range(9) == 0) ? $urandom_range(9, 48) : $urandom_range(1, 8);
            h = $urandom_range(1, 6);
            set_frame_size(12'(w), 16'(h));
            play_frames(12'(w), 16'(h), $urandom_range(1, 3), 4);
        end
    endtask

    initial begin
        t_pix corner_px[9];
        sb = new();
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= REG_WIDTH;
        i_cfg_data      <= '0;
        pix_if.valid    <= 1'b0;
        pix_if.blue_in  <= '0;
        pix_if.green_in <= '0;
        pix_if.red_in   <= '0;
        pix_if.drain    <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // no idling on either side
        send_idle_pct = 0;
        stall_pct     = 0;

        // 3x3 frame: every divisor from corner to centre, full-scale and zero
        // channels, the centre pixel replaced by a drain word
        corner_px = '{24'h000000, 24'hFFFFFF, 24'h0F55AA, 24'hFF00FF, 24'h000000,
                      24'h00FF00, 24'h123456, 24'hFEDCBA, 24'h808080};
        set_frame_size(12'd3, 16'd3);
        foreach (corner_px[i]) push_word(corner_px[i], i == 4);
        repeat (4) push_word(24'hFFFFFF, 1'b1);

        // zero width and zero height both act as one
        set_frame_size(12'd0, 16'd0);
        play_frames(12'd0, 16'd0, 1, 0);

        // receiver holds off while the sender keeps offering: the block fills up
        set_frame_size(12'd8, 16'd8);
        holds_asked++;
        play_frames(12'd8, 16'd8, 2, 0);

        random_frames(RANDOM_WORDS);

        // single-pixel frames back to back
        set_frame_size(12'd1, 16'd1);
        play_frames(12'd1, 16'd1, 3, 0);

        // sender idles most of the time
        send_idle_pct = 86;
        stall_pct     = 0;
        random_frames(RANDOM_WORDS);

        // receiver stalls most of the time
        send_idle_pct = 0;
        stall_pct     = 86;
        random_frames(RANDOM_WORDS);

        // light idling on both sides
        send_idle_pct = 20;
        stall_pct     = 20;
        random_frames(RANDOM_WORDS);

        pix_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
